// ----- sv/rtb_pkg.sv -----
package rtb_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0] FOREIGN_LIMIT = 8'h80;

  // register indexes of the configuration port
  localparam logic [2:0] REG_BASE  = 3'd0;
  localparam logic [2:0] REG_LIMIT = 3'd1;
  localparam logic [2:0] REG_DATA  = 3'd2;
  localparam logic [2:0] REG_SYN   = 3'd3;
  localparam logic [2:0] REG_FIN   = 3'd4;
  localparam logic [2:0] REG_ACK   = 3'd5;

  localparam logic [15:0] RST_BASE  = 16'd500;
  localparam logic [3:0]  RST_LIMIT = 4'd5;
  localparam logic [7:0]  RST_DATA  = 8'd129;
  localparam logic [7:0]  RST_SYN   = 8'd130;
  localparam logic [7:0]  RST_FIN   = 8'd131;
  localparam logic [7:0]  RST_ACK   = 8'd128;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_RECV = 2'd1,
    CMD_TICK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OP_SEND,
    OP_RX,
    OP_FOREIGN,
    OP_TICK
  } op_t;

  typedef enum logic [3:0] {
    EV_SENT    = 4'd0,
    EV_NOSLOT  = 4'd1,
    EV_SENDACK = 4'd2,
    EV_ACKCLR  = 4'd3,
    EV_RXNONE  = 4'd4,
    EV_FOREIGN = 4'd5,
    EV_RETX    = 4'd6,
    EV_DROP    = 4'd7,
    EV_NONE    = 4'd8
  } evt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ACK,
    S_RXFIN,
    S_TICK,
    S_TEND
  } st_t;

  typedef struct packed {
    logic [15:0] base_timeout_ms;
    logic [3:0]  retry_limit;
    logic [7:0]  code_data;
    logic [7:0]  code_syn;
    logic [7:0]  code_fin;
    logic [7:0]  code_ack;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic        rel;
    logic        ack;
    logic [7:0]  typ;
    logic [31:0] rseq;
    logic [31:0] rack;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    evt_t        kind;
    logic [3:0]  slot;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  typ;
    logic [3:0]  att;
    logic [31:0] tmo;
    logic        last;
  } res_t;

  function automatic logic [3:0] slot_out(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+3:0] ext;
    ext = {4'b0000, idx};
    return ext[3:0];
  endfunction

endpackage

// ----- sv/rtb_front.sv -----
module rtb_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [7:0]           packet_type,
  input  logic [31:0]          rx_sequence,
  input  logic [31:0]          rx_ack_number,
  input  logic [31:0]          now_ms,
  input  rtb_pkg::cfg_t        cfg,
  input  logic                 q_full,
  output logic                 push,
  output rtb_pkg::item_t       push_item
);

  logic rel;

  assign rel = (packet_type == cfg.code_data) || (packet_type == cfg.code_syn) ||
               (packet_type == cfg.code_fin);
  assign in_ready = !q_full;

  always_comb begin
    push_item      = '0;
    push_item.rel  = rel;
    push_item.ack  = (packet_type == cfg.code_ack);
    push_item.typ  = packet_type;
    push_item.rseq = rx_sequence;
    push_item.rack = rx_ack_number;
    push_item.now  = now_ms;
    push           = in_valid && in_ready;
    case (command)
      rtb_pkg::CMD_SEND: push_item.op = rtb_pkg::OP_SEND;
      rtb_pkg::CMD_RECV: begin
        if (packet_type < rtb_pkg::FOREIGN_LIMIT) begin
          push_item.op = rtb_pkg::OP_FOREIGN;
        end else begin
          push_item.op = rtb_pkg::OP_RX;
        end
      end
      rtb_pkg::CMD_TICK: push_item.op = rtb_pkg::OP_TICK;
      default: push = 1'b0; // drop the unused command code
    endcase
  end

endmodule

// ----- sv/rtb_queue.sv -----
module rtb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rtb_pkg::item_t push_item,
  output logic           q_full,
  input  logic           pop,
  output logic           q_valid,
  output rtb_pkg::item_t q_item
);

  rtb_pkg::item_t              store [rtb_pkg::QDEPTH];
  logic [rtb_pkg::QPTR_W-1:0]  wr_ptr;
  logic [rtb_pkg::QPTR_W-1:0]  rd_ptr;
  logic [rtb_pkg::QCNT_W-1:0]  count;

  localparam logic [rtb_pkg::QPTR_W-1:0] PTR_LAST = rtb_pkg::QPTR_W'(rtb_pkg::QDEPTH - 1);

  assign q_full  = (count == rtb_pkg::QCNT_W'(rtb_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign q_item  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + rtb_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + rtb_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + rtb_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - rtb_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- sv/rtb_back.sv -----
module rtb_back (
  input  logic           clk,
  input  logic           rst,
  input  rtb_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  rtb_pkg::item_t q_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output rtb_pkg::res_t  out_res
);

  localparam int SW = rtb_pkg::SLOT_W;
  localparam logic [SW-1:0] IDX_LAST = SW'(rtb_pkg::SLOTS - 1);

  rtb_pkg::st_t   state;
  rtb_pkg::st_t   state_next;
  rtb_pkg::item_t cur;
  logic [SW-1:0]  idx;
  logic           matched;
  logic [rtb_pkg::CNT_W-1:0] cnt;
  logic           pend_valid;
  rtb_pkg::res_t  pend;
  logic [31:0]    next_sequence;
  logic [31:0]    last_acked;

  logic [rtb_pkg::SLOTS-1:0] entry_valid;
  logic [31:0] entry_seq     [rtb_pkg::SLOTS];
  logic [7:0]  entry_type    [rtb_pkg::SLOTS];
  logic [31:0] entry_stamp   [rtb_pkg::SLOTS];
  logic [3:0]  entry_retries [rtb_pkg::SLOTS];

  logic          rd_valid;
  logic [31:0]   rd_seq;
  logic [7:0]    rd_type;
  logic [31:0]   rd_stamp;
  logic [3:0]    rd_retries;
  logic [31:0]   tmo;
  logic [31:0]   age;
  logic          due;
  logic          scan_last;
  logic          can_load;
  logic          any_free;
  logic [SW-1:0] free_idx;

  logic          load_out;
  rtb_pkg::res_t out_new;
  logic          pend_load;
  logic          pend_clear;
  rtb_pkg::res_t pend_new;
  logic          idx_inc;
  logic          ins;
  logic          clr_valid;
  logic          upd;
  logic          seq_adv;
  logic          la_we;
  logic          matched_set;

  assign rd_valid   = entry_valid[idx];
  assign rd_seq     = entry_seq[idx];
  assign rd_type    = entry_type[idx];
  assign rd_stamp   = entry_stamp[idx];
  assign rd_retries = entry_retries[idx];
  // widest shift is 16 + 15 bits, so the 32-bit timeout never saturates
  assign tmo        = 32'(cfg.base_timeout_ms) << rd_retries;
  assign age        = cur.now - rd_stamp;
  assign due        = rd_valid && (age > tmo);
  assign scan_last  = (idx == IDX_LAST);
  assign can_load   = !out_valid || out_ready;

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = rtb_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        any_free = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    load_out    = 1'b0;
    out_new     = '0;
    pend_load   = 1'b0;
    pend_clear  = 1'b0;
    pend_new    = '0;
    idx_inc     = 1'b0;
    ins         = 1'b0;
    clr_valid   = 1'b0;
    upd         = 1'b0;
    seq_adv     = 1'b0;
    la_we       = 1'b0;
    matched_set = 1'b0;
    case (state)
      rtb_pkg::S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_item.op)
            rtb_pkg::OP_RX:   state_next = q_item.ack ? rtb_pkg::S_ACK : rtb_pkg::S_RXFIN;
            rtb_pkg::OP_TICK: state_next = rtb_pkg::S_TICK;
            default:          state_next = rtb_pkg::S_EXEC;
          endcase
        end
      end
      rtb_pkg::S_EXEC: begin
        out_new.typ  = cur.typ;
        out_new.last = 1'b1;
        if (can_load) begin
          load_out   = 1'b1;
          state_next = rtb_pkg::S_IDLE;
          if (cur.op == rtb_pkg::OP_FOREIGN) begin
            out_new.kind = rtb_pkg::EV_FOREIGN;
          end else if (cur.rel && !any_free) begin
            out_new.kind = rtb_pkg::EV_NOSLOT;
          end else begin
            out_new.kind = rtb_pkg::EV_SENT;
            out_new.slot = cur.rel ? rtb_pkg::slot_out(free_idx) : 4'd0;
            out_new.seq  = next_sequence;
            out_new.ack  = last_acked;
            seq_adv      = 1'b1;
            ins          = cur.rel;
          end
        end
      end
      rtb_pkg::S_ACK: begin
        if (rd_valid && (rd_seq == cur.rack)) begin
          out_new.kind = rtb_pkg::EV_ACKCLR;
          out_new.slot = rtb_pkg::slot_out(idx);
          out_new.seq  = rd_seq;
          out_new.typ  = cur.typ;
          out_new.last = !cur.rel;
          if (can_load) begin
            load_out    = 1'b1;
            clr_valid   = 1'b1;
            matched_set = 1'b1;
            state_next  = rtb_pkg::S_RXFIN;
          end
        end else if (scan_last) begin
          state_next = rtb_pkg::S_RXFIN;
        end else begin
          idx_inc = 1'b1;
        end
      end
      rtb_pkg::S_RXFIN: begin
        out_new.typ  = cur.typ;
        out_new.last = 1'b1;
        if (cur.rel) begin
          out_new.kind = rtb_pkg::EV_SENDACK;
          out_new.seq  = next_sequence;
          out_new.ack  = cur.rseq;
          if (can_load) begin
            load_out   = 1'b1;
            la_we      = 1'b1;
            state_next = rtb_pkg::S_IDLE;
          end
        end else if (!matched) begin
          out_new.kind = rtb_pkg::EV_RXNONE;
          out_new.seq  = cur.rseq;
          if (can_load) begin
            load_out   = 1'b1;
            state_next = rtb_pkg::S_IDLE;
          end
        end else begin
          state_next = rtb_pkg::S_IDLE;
        end
      end
      rtb_pkg::S_TICK: begin
        pend_new.slot = rtb_pkg::slot_out(idx);
        pend_new.seq  = rd_seq;
        pend_new.ack  = last_acked;
        pend_new.typ  = rd_type;
        pend_new.tmo  = tmo;
        if (rd_retries < cfg.retry_limit) begin
          pend_new.kind = rtb_pkg::EV_RETX;
          pend_new.att  = rd_retries + 4'd1;
        end else begin
          pend_new.kind = rtb_pkg::EV_DROP;
          pend_new.att  = rd_retries;
        end
        out_new = pend;
        if (cnt == rtb_pkg::CNT_W'(rtb_pkg::MAX_RESULTS)) begin
          state_next = rtb_pkg::S_TEND;
        end else if (due) begin
          // hold the new result back until the scan shows whether it is the last
          if (!pend_valid || can_load) begin
            load_out  = pend_valid;
            pend_load = 1'b1;
            upd       = (rd_retries < cfg.retry_limit);
            clr_valid = !(rd_retries < cfg.retry_limit);
            if (scan_last) begin
              state_next = rtb_pkg::S_TEND;
            end else begin
              idx_inc = 1'b1;
            end
          end
        end else if (scan_last) begin
          state_next = rtb_pkg::S_TEND;
        end else begin
          idx_inc = 1'b1;
        end
      end
      rtb_pkg::S_TEND: begin
        if (pend_valid) begin
          out_new = pend;
        end else begin
          out_new.kind = rtb_pkg::EV_NONE;
        end
        out_new.last = 1'b1;
        if (can_load) begin
          load_out   = 1'b1;
          pend_clear = 1'b1;
          state_next = rtb_pkg::S_IDLE;
        end
      end
      default: state_next = rtb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rtb_pkg::S_IDLE;
      out_valid     <= 1'b0;
      pend_valid    <= 1'b0;
      next_sequence <= 32'd1;
      last_acked    <= '0;
      entry_valid   <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_clear) begin
        pend_valid <= 1'b0;
      end
      if (seq_adv) begin
        next_sequence <= next_sequence + 32'd1;
      end
      if (la_we) begin
        last_acked <= cur.rseq;
      end
      if (ins) begin
        entry_valid[free_idx] <= 1'b1;
      end
      if (clr_valid) begin
        entry_valid[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= q_item;
      idx     <= '0;
      matched <= 1'b0;
      cnt     <= '0;
    end else begin
      if (idx_inc) begin
        idx <= idx + SW'(1);
      end
      if (matched_set) begin
        matched <= 1'b1;
      end
      if (pend_load) begin
        cnt <= cnt + rtb_pkg::CNT_W'(1);
      end
    end
    if (load_out) begin
      out_res <= out_new;
    end
    if (pend_load) begin
      pend <= pend_new;
    end
    if (ins) begin
      entry_seq[free_idx]     <= next_sequence;
      entry_type[free_idx]    <= cur.typ;
      entry_stamp[free_idx]   <= cur.now;
      entry_retries[free_idx] <= 4'd0;
    end
    if (upd) begin
      entry_retries[idx] <= rd_retries + 4'd1;
      entry_stamp[idx]   <= cur.now;
    end
  end

endmodule

// ----- sv/retransmit_tracker_backoff.sv -----
// Retransmission table with exponential backoff.
// Input channel (in_valid/in_ready): one word per command: send, receive or
// time tick. Output channel (out_valid/out_ready): result words; the last word
// caused by an input word carries last_of_run. Configuration is written
// through cfg_we/cfg_index/cfg_data, one register per cycle; the user must
// write it only while idle, which the block does not enforce. Accepted words
// pass a classifier into a two-entry queue; a sequencer drains the queue one
// word at a time and owns the slot table. With the queue empty and the
// sequencer idle, a send or foreign receive result passes the queue, the
// sequencer's item register and the output register; the last result of an
// ack receive or a tick comes after its scan. An ack receive and a tick scan
// the table one slot per cycle while the output is not stalled; the slot
// scan sets the rate.
// Reset: the table is empty, the sequence counter is 1, the last acked number
// is 0 and the registers take their default values.
// A stalled receiver holds the output register; the sequencer then waits,
// and the input side keeps taking words until the queue is full.
module retransmit_tracker_backoff (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  packet_type,
  input  logic [31:0] rx_sequence,
  input  logic [31:0] rx_ack_number,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  event_kind,
  output logic [3:0]  slot_index,
  output logic [31:0] seq_number,
  output logic [31:0] ack_value,
  output logic [7:0]  result_type,
  output logic [3:0]  attempt,
  output logic [31:0] timeout_used,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rtb_pkg::cfg_t  cfg;
  logic           q_full;
  logic           push;
  rtb_pkg::item_t push_item;
  logic           q_valid;
  logic           pop;
  rtb_pkg::item_t q_item;
  rtb_pkg::res_t  out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_timeout_ms <= rtb_pkg::RST_BASE;
      cfg.retry_limit     <= rtb_pkg::RST_LIMIT;
      cfg.code_data       <= rtb_pkg::RST_DATA;
      cfg.code_syn        <= rtb_pkg::RST_SYN;
      cfg.code_fin        <= rtb_pkg::RST_FIN;
      cfg.code_ack        <= rtb_pkg::RST_ACK;
    end else if (cfg_we) begin
      case (cfg_index)
        rtb_pkg::REG_BASE:  cfg.base_timeout_ms <= cfg_data;
        rtb_pkg::REG_LIMIT: cfg.retry_limit     <= cfg_data[3:0];
        rtb_pkg::REG_DATA:  cfg.code_data       <= cfg_data[7:0];
        rtb_pkg::REG_SYN:   cfg.code_syn        <= cfg_data[7:0];
        rtb_pkg::REG_FIN:   cfg.code_fin        <= cfg_data[7:0];
        rtb_pkg::REG_ACK:   cfg.code_ack        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rtb_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .packet_type   (packet_type),
    .rx_sequence   (rx_sequence),
    .rx_ack_number (rx_ack_number),
    .now_ms        (now_ms),
    .cfg           (cfg),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  rtb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  rtb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign event_kind   = out_res.kind;
  assign slot_index   = out_res.slot;
  assign seq_number   = out_res.seq;
  assign ack_value    = out_res.ack;
  assign result_type  = out_res.typ;
  assign attempt      = out_res.att;
  assign timeout_used = out_res.tmo;
  assign last_of_run  = out_res.last;

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("sequencer popped an empty queue");

  a_push_space: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("word pushed into a full queue");

  a_none_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_kind == rtb_pkg::EV_NONE)) |-> last_of_run)
    else $error("nothing-due result not marked last");

  a_noslot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_kind == rtb_pkg::EV_NOSLOT)) |-> (last_of_run && (seq_number == '0)))
    else $error("refused send carries a sequence number");
`endif

endmodule
